// ===== rtl/core/csbt_pkg.sv =====
// Shared types and constants of the shadow call stack tracker.
`timescale 1ns / 1ps
package csbt_pkg;

	localparam int ADDR_W      = 64;
	localparam int WANT_W      = 7;
	localparam int CMD_W       = 2;
	localparam int STATUS_W    = 2;
	localparam int IN_TDATA_W  = 72;
	localparam int WANT_LSB    = ADDR_W;
	localparam int OUT_TUSER_W = STATUS_W + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_TRACE = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic    from_mem;
		logic    last;
		status_t status;
	} out_ctl_t;

endpackage

// ===== rtl/core/call_stack_backtrace_tracker.sv =====
// Top level of the shadow call stack tracker.
// Usage:
//   Input stream s_axis: tuser carries the command (push, pop, backtrace),
//   tdata carries the return address to push and the backtrace entry limit.
//   Output stream m_axis: one transfer per push, pop or unused command, with
//   tlast set and status in tuser; a backtrace yields one transfer per
//   reported entry, newest first, tlast on the final one, or a single empty
//   transfer when nothing is reported. The bottom-most entry is never shown.
// Ordering and throughput:
//   Push, pop and unused commands have their result in the output register
//   the cycle after the input transfer; one such item is accepted every
//   cycle while the output register is free. A backtrace first loads its
//   read index and entry count, then streams one entry per cycle through
//   the single RAM read port when not stalled; no input is taken meanwhile.
// Reset clears the entry count and the output register; stack contents are
// not cleared. When the receiver stalls, the output register and RAM read
// data hold, and the input side stops once the output register is full.
`timescale 1ns / 1ps
module call_stack_backtrace_tracker #(
	parameter int STACK_DEPTH = 128,
	parameter int MAX_TRACE   = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [csbt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // return_addr[63:0], want_count[6:0]
	input  logic [csbt_pkg::CMD_W-1:0]          s_axis_tuser,  // cmd[1:0]
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [csbt_pkg::ADDR_W-1:0]         m_axis_tdata,  // addr[63:0]
	output logic [csbt_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,  // valid_res, status[1:0]
	output logic                                m_axis_tlast
);
	import csbt_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int IW = $clog2(STACK_DEPTH);
	localparam int TW = $clog2(MAX_TRACE + 1);
	localparam int XW = (CW > WANT_W) ? CW : WANT_W;

	typedef enum logic {ST_IDLE, ST_TRACE} state_t;

	state_t          state_q;
	logic [CW-1:0]   top_q;
	logic [IW-1:0]   idx_q;
	logic [TW-1:0]   left_q;

	cmd_t            cmd;
	logic [ADDR_W-1:0] ret_addr;
	logic [WANT_W-1:0] want;
	logic            accept;
	logic            out_free;
	logic            full;
	logic            empty;
	logic [CW-1:0]   top_m1;
	logic [CW-1:0]   avail;
	logic [WANT_W-1:0] cap;
	logic [XW-1:0]   n_x;
	logic [TW-1:0]   n;
	logic            rd_en;
	logic            we;
	logic            load;
	out_ctl_t        ctl;
	logic [ADDR_W-1:0] rd_data;

	assign cmd      = cmd_t'(s_axis_tuser);
	assign ret_addr = s_axis_tdata[ADDR_W-1:0];
	assign want     = s_axis_tdata[WANT_LSB +: WANT_W];
	assign full     = (top_q == CW'(STACK_DEPTH));
	assign empty    = (top_q == '0);
	assign top_m1   = top_q - CW'(1);
	assign avail    = empty ? '0 : top_m1;
	assign cap      = (want > WANT_W'(MAX_TRACE)) ? WANT_W'(MAX_TRACE) : want;
	assign n_x      = (XW'(avail) < XW'(cap)) ? XW'(avail) : XW'(cap);
	assign n        = n_x[TW-1:0];

	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign rd_en         = (state_q == ST_TRACE) && out_free;
	assign we            = accept && (cmd == CMD_PUSH) && !full;

	always_comb begin
		load = 1'b0;
		ctl  = '{from_mem: 1'b0, last: 1'b1, status: STAT_OK};
		if (rd_en) begin
			load         = 1'b1;
			ctl.from_mem = 1'b1;
			ctl.last     = (left_q == TW'(1));
		end else if (accept) begin
			load = 1'b1;
			unique case (cmd)
				CMD_PUSH:  ctl.status = full ? STAT_FULL : STAT_OK;
				CMD_POP:   ctl.status = empty ? STAT_EMPTY : STAT_OK;
				CMD_TRACE: load = (n == '0);
				CMD_NONE:  ctl.status = STAT_OK;
				default:   ctl.status = STAT_OK;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			top_q   <= '0;
			idx_q   <= '0;
			left_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (cmd)
							CMD_PUSH: begin
								if (!full) top_q <= top_q + CW'(1);
							end
							CMD_POP: begin
								if (!empty) top_q <= top_m1;
							end
							CMD_TRACE: begin
								if (n != '0) begin
									state_q <= ST_TRACE;
									idx_q   <= top_m1[IW-1:0];
									left_q  <= n;
								end
							end
							CMD_NONE: begin
								state_q <= ST_IDLE;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_TRACE: begin
					if (rd_en) begin
						idx_q  <= idx_q - IW'(1);
						left_q <= left_q - TW'(1);
						if (left_q == TW'(1)) state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	csbt_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk  (clk),
		.we   (we),
		.waddr(top_q[IW-1:0]),
		.wdata(ret_addr),
		.re   (rd_en),
		.raddr(idx_q),
		.rdata(rd_data)
	);

	csbt_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (load),
		.ctl          (ctl),
		.mem_data     (rd_data),
		.free         (out_free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	a_top_bound: assert property (@(posedge clk) disable iff (!arst_n)
		top_q <= CW'(STACK_DEPTH))
		else $error("entry count exceeds stack depth");

	a_no_input_in_trace: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRACE) |-> !s_axis_tready)
		else $error("input accepted while a backtrace streams");

	a_trace_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRACE) |-> (left_q != '0))
		else $error("backtrace running with nothing left to report");

	a_trace_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && left_q == TW'(1)) |=> (state_q == ST_IDLE))
		else $error("backtrace did not end after its last entry");

	a_no_write_in_trace: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRACE) |-> !we)
		else $error("stack written while a backtrace reads it");

endmodule

// ===== rtl/core/csbt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module csbt_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/csbt_out_stage.sv =====
// Output register stage of the result stream.
`timescale 1ns / 1ps
module csbt_out_stage (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   load,
	input  csbt_pkg::out_ctl_t                     ctl,
	input  logic [csbt_pkg::ADDR_W-1:0]            mem_data,
	output logic                                   free,
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	output logic [csbt_pkg::ADDR_W-1:0]            m_axis_tdata,  // addr
	output logic [csbt_pkg::OUT_TUSER_W-1:0]       m_axis_tuser,  // valid_res, status[1:0]
	output logic                                   m_axis_tlast
);
	import csbt_pkg::*;

	logic     valid_q;
	out_ctl_t ctl_q;

	// The address itself lives in the RAM read register, which holds while stalled.
	assign free          = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = ctl_q.from_mem ? mem_data : '0;
	assign m_axis_tuser  = {ctl_q.status, ctl_q.from_mem};
	assign m_axis_tlast  = ctl_q.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			ctl_q   <= '0;
		end else if (free) begin
			valid_q <= load;
			if (load) begin
				ctl_q <= ctl;
			end
		end
	end

endmodule

// ===== verif/tb_call_stack_backtrace_tracker.sv =====
// Self-checking testbench for the shadow call stack tracker.
`timescale 1ns / 1ps
module tb_call_stack_backtrace_tracker;
	import csbt_pkg::*;

	localparam int STACK_DEPTH = 128;
	localparam int MAX_TRACE   = 64;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic              valid_res;
		logic              last;
		status_t           status;
	} trace_beat_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [CMD_W-1:0]       s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [ADDR_W-1:0]      m_axis_tdata;
	logic [OUT_TUSER_W-1:0] m_axis_tuser;
	logic                   m_axis_tlast;

	// Shadow copy of the stack, updated when an input transfer is accepted.
	logic [ADDR_W-1:0] stack_mirror [STACK_DEPTH];
	int unsigned       mirror_top;
	trace_beat_t       beats_due [$];
	trace_beat_t       head_beat;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned items_sent;
	int unsigned beats_seen;
	int unsigned entries_reported;
	int unsigned full_refusals;
	int unsigned empty_refusals;
	int unsigned fail_count;
	int unsigned cycle_count;

	call_stack_backtrace_tracker #(
		.STACK_DEPTH(STACK_DEPTH),
		.MAX_TRACE  (MAX_TRACE)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void queue_beat(logic [ADDR_W-1:0] addr, logic valid_res, logic last,
			status_t status);
		trace_beat_t b;
		b.addr      = addr;
		b.valid_res = valid_res;
		b.last      = last;
		b.status    = status;
		beats_due.push_back(b);
	endfunction

	// Works out the results of one accepted command and updates the shadow stack.
	function automatic void predict_stack_op(cmd_t cmd, logic [ADDR_W-1:0] ret_addr,
			logic [WANT_W-1:0] want);
		int unsigned avail;
		int unsigned n;
		case (cmd)
			CMD_PUSH: begin
				if (mirror_top >= STACK_DEPTH) begin
					queue_beat('0, 1'b0, 1'b1, STAT_FULL);
					full_refusals++;
				end else begin
					stack_mirror[mirror_top] = ret_addr;
					mirror_top++;
					queue_beat('0, 1'b0, 1'b1, STAT_OK);
				end
			end
			CMD_POP: begin
				if (mirror_top == 0) begin
					queue_beat('0, 1'b0, 1'b1, STAT_EMPTY);
					empty_refusals++;
				end else begin
					mirror_top--;
					queue_beat('0, 1'b0, 1'b1, STAT_OK);
				end
			end
			CMD_TRACE: begin
				// The bottom entry is never reported, so one entry yields nothing.
				avail = (mirror_top > 0) ? mirror_top - 1 : 0;
				n = want;
				if (n > MAX_TRACE) n = MAX_TRACE;
				if (n > avail) n = avail;
				if (n == 0) begin
					queue_beat('0, 1'b0, 1'b1, STAT_OK);
				end else begin
					for (int unsigned i = 0; i < n; i++)
						queue_beat(stack_mirror[mirror_top - 1 - i], 1'b1, i + 1 == n, STAT_OK);
					entries_reported += n;
				end
			end
			default: begin
				queue_beat('0, 1'b0, 1'b1, STAT_OK);
			end
		endcase
	endfunction

	// Presents one command and waits for its transfer; valid stays high into the
	// next call unless an idle cycle is taken first.
	task automatic send_op(cmd_t cmd, logic [ADDR_W-1:0] ret_addr, logic [WANT_W-1:0] want);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, want, ret_addr};
		s_axis_tuser  <= cmd;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_stack_op(cmd, ret_addr, want);
		items_sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [ADDR_W-1:0] rand_addr();
		case ($urandom_range(19))
			0: return '1;
			1: return '0;
			2: return {1'b1, {(ADDR_W-1){1'b0}}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [WANT_W-1:0] rand_want();
		if ($urandom_range(4) == 0) return WANT_W'($urandom_range(127));
		return WANT_W'($urandom_range(8));
	endfunction

	task automatic test_corner_cases();
		send_op(CMD_POP, '1, 7'd0);
		send_op(CMD_TRACE, '0, 7'd5);
		send_op(CMD_NONE, '1, 7'd127);
		send_op(CMD_PUSH, '1, 7'd127);
		send_op(CMD_TRACE, '1, 7'd127);
		send_op(CMD_PUSH, '0, 7'd0);
		send_op(CMD_TRACE, '0, 7'd0);
		send_op(CMD_TRACE, '0, 7'd1);
		send_op(CMD_PUSH, 64'hA5A5_A5A5_A5A5_A5A5, 7'd85);
		send_op(CMD_PUSH, 64'h5A5A_5A5A_5A5A_5A5A, 7'd42);
		send_op(CMD_TRACE, 64'h5A5A_5A5A_5A5A_5A5A, 7'd127);
		send_op(CMD_TRACE, '1, 7'd2);
		send_op(CMD_TRACE, '0, 7'd64);
		send_op(CMD_NONE, '0, 7'd0);
		repeat (4) send_op(CMD_POP, '0, 7'd127);
		send_op(CMD_POP, '1, 7'd0);
		send_op(CMD_TRACE, '1, 7'd127);
	endtask

	task automatic test_fill_and_overflow();
		while (mirror_top < STACK_DEPTH) send_op(CMD_PUSH, rand_addr(), rand_want());
		send_op(CMD_PUSH, '1, 7'd0);
		send_op(CMD_TRACE, rand_addr(), 7'd127);
		send_op(CMD_TRACE, rand_addr(), 7'd64);
		send_op(CMD_TRACE, rand_addr(), 7'd63);
		// Hold the input side until the long backtraces have fully drained.
		wait_drained();
		// Drop a few entries so the later call chains run close to the full mark.
		repeat (8) send_op(CMD_POP, rand_addr(), rand_want());
		send_op(CMD_TRACE, rand_addr(), 7'd10);
	endtask

	// Mostly nested call chains with backtraces inside, mixed with random noise.
	task automatic test_call_chains(int unsigned n_ops);
		int unsigned start;
		int unsigned depth;
		int unsigned k;
		start = items_sent;
		while (items_sent - start < n_ops) begin
			if ($urandom_range(99) < 70) begin
				depth = $urandom_range(1, 6);
				for (k = 0; k < depth; k++) begin
					send_op(CMD_PUSH, rand_addr(), rand_want());
					if ($urandom_range(3) == 0) send_op(CMD_TRACE, rand_addr(), rand_want());
				end
				send_op(CMD_TRACE, rand_addr(), rand_want());
				for (k = 0; k < depth; k++) send_op(CMD_POP, rand_addr(), rand_want());
			end else begin
				case ($urandom_range(19))
					0, 1, 2, 3, 4, 5, 6: send_op(CMD_PUSH, rand_addr(), rand_want());
					7, 8, 9, 10, 11, 12: send_op(CMD_POP, rand_addr(), rand_want());
					13, 14, 15, 16, 17: send_op(CMD_TRACE, rand_addr(), rand_want());
					default: send_op(CMD_NONE, rand_addr(), rand_want());
				endcase
			end
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			beats_seen++;
			if (beats_due.size() == 0) begin
				$error("unexpected result transfer: addr %h", m_axis_tdata);
				fail_count++;
			end else begin
				head_beat = beats_due.pop_front();
				if (m_axis_tdata !== head_beat.addr) begin
					$error("addr: expected %h, got %h", head_beat.addr, m_axis_tdata);
					fail_count++;
				end
				if (m_axis_tuser[0] !== head_beat.valid_res) begin
					$error("valid_res: expected %b, got %b", head_beat.valid_res, m_axis_tuser[0]);
					fail_count++;
				end
				if (m_axis_tlast !== head_beat.last) begin
					$error("last: expected %b, got %b", head_beat.last, m_axis_tlast);
					fail_count++;
				end
				if (m_axis_tuser[2:1] !== head_beat.status) begin
					$error("status: expected %0d, got %0d", head_beat.status, m_axis_tuser[2:1]);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, beats_due.size());
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		arst_n         <= 1'b0;
		s_axis_tvalid  <= 1'b0;
		s_axis_tdata   <= '0;
		s_axis_tuser   <= CMD_PUSH;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		mirror_top     = 0;
		items_sent     = 0;
		beats_seen     = 0;
		entries_reported = 0;
		full_refusals  = 0;
		empty_refusals = 0;
		fail_count     = 0;
		cycle_count    = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();

		recv_stall_pct = 76;
		test_fill_and_overflow();

		send_idle_pct = 0;  recv_stall_pct = 0;
		test_call_chains(14);
		send_idle_pct = 76; recv_stall_pct = 0;
		test_call_chains(14);
		send_idle_pct = 0;  recv_stall_pct = 76;
		test_call_chains(14);
		send_idle_pct = 37; recv_stall_pct = 37;
		test_call_chains(14);

		wait_drained();
		repeat (20) @(posedge clk);

		$display("Sent %0d commands, checked %0d result transfers (%0d stack entries reported).",
			items_sent, beats_seen, entries_reported);
		$display("Refused pushes on a full stack: %0d, refused pops on an empty stack: %0d.",
			full_refusals, empty_refusals);
		if (fail_count == 0 && beats_due.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
